[hdl/crc16fp_pkg.sv]
`timescale 1ns / 1ps
// shared types, constants and the crc byte update for the framed packet parser
// no dependencies

package crc16fp_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int PTR_W       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_MSB  = 16'h8000;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_VER    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_LIMIT  = 2'd2;

  localparam logic [7:0] START_BYTE_RST = 8'hAA;
  localparam logic [7:0] EXP_VER_RST    = 8'h01;
  localparam logic [5:0] LEN_LIMIT_RST  = 6'd32;

  typedef enum logic [1:0] {
    KIND_GOOD        = 2'd0,
    KIND_BAD_VERSION = 2'd1,
    KIND_BAD_LENGTH  = 2'd2,
    KIND_BAD_CRC     = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_HUNT,
    ST_VERSION,
    ST_TYPE,
    ST_SEQ_L,
    ST_SEQ_H,
    ST_LEN_L,
    ST_LEN_H,
    ST_PAYLOAD,
    ST_CRC_L,
    ST_CRC_H,
    ST_PRIME,
    ST_REPLAY
  } state_t;

  typedef enum logic [3:0] {
    CAP_NONE,
    CAP_START,
    CAP_VERSION,
    CAP_TYPE,
    CAP_SEQ_L,
    CAP_SEQ_H,
    CAP_LEN_L,
    CAP_LEN_H,
    CAP_PAYLOAD,
    CAP_CRC_L
  } capture_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_DATA,
    EMIT_EMPTY,
    EMIT_BAD_VERSION,
    EMIT_BAD_LENGTH,
    EMIT_BAD_CRC
  } emit_t;

  typedef struct packed {
    capture_t capture;
    emit_t    emit;
    logic     replay_start;
    logic     replay_step;
  } cmd_t;

  typedef struct packed {
    logic start_match;
    logic version_bad;
    logic len_bad;
    logic len_zero;
    logic payload_done;
    logic crc_good;
    logic hdr_len_zero;
    logic replay_last;
    logic out_free;
  } status_t;

  // crc-16/ccitt-false, msb first, one byte
  function automatic logic [15:0] crc_step(input logic [15:0] crc_in,
                                           input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[hdl/crc16fp_ifs.sv]
`timescale 1ns / 1ps
// valid/ready channel interfaces: received bytes, results, register writes
// no dependencies

interface crc16fp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface crc16fp_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  pkt_type;
  logic [15:0] seq_number;
  logic [15:0] pkt_len;
  logic [7:0]  error_detail;
  logic [7:0]  data_byte;
  logic        data_valid;
  logic        last;
  modport source (output valid, output kind, output pkt_type, output seq_number,
                  output pkt_len, output error_detail, output data_byte,
                  output data_valid, output last, input ready);
  modport sink (input valid, input kind, input pkt_type, input seq_number,
                input pkt_len, input error_detail, input data_byte,
                input data_valid, input last, output ready);
endinterface

interface crc16fp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/crc16fp_ctrl.sv]
`timescale 1ns / 1ps
// frame parser controller: phase state machine issuing datapath commands
// depends on crc16fp_pkg

module crc16fp_ctrl
  import crc16fp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    cmd.capture      = CAP_NONE;
    cmd.emit         = EMIT_NONE;
    cmd.replay_start = 1'b0;
    cmd.replay_step  = 1'b0;
    in_ready         = 1'b1;
    take             = 1'b0;
    unique case (state) inside
      ST_LEN_H, ST_CRC_H: in_ready = status.out_free;
      ST_PRIME, ST_REPLAY: in_ready = 1'b0;
      default: in_ready = 1'b1;
    endcase
    take = in_valid && in_ready;
    unique case (state)
      ST_HUNT: begin
        if (take && status.start_match) begin
          cmd.capture = CAP_START;
          state_next  = ST_VERSION;
        end
      end
      ST_VERSION: begin
        if (take) begin
          cmd.capture = CAP_VERSION;
          state_next  = ST_TYPE;
        end
      end
      ST_TYPE: begin
        if (take) begin
          cmd.capture = CAP_TYPE;
          state_next  = ST_SEQ_L;
        end
      end
      ST_SEQ_L: begin
        if (take) begin
          cmd.capture = CAP_SEQ_L;
          state_next  = ST_SEQ_H;
        end
      end
      ST_SEQ_H: begin
        if (take) begin
          cmd.capture = CAP_SEQ_H;
          state_next  = ST_LEN_L;
        end
      end
      ST_LEN_L: begin
        if (take) begin
          cmd.capture = CAP_LEN_L;
          state_next  = ST_LEN_H;
        end
      end
      ST_LEN_H: begin
        if (take) begin
          cmd.capture = CAP_LEN_H;
          if (status.version_bad) begin
            cmd.emit   = EMIT_BAD_VERSION;
            state_next = ST_HUNT;
          end else if (status.len_bad) begin
            cmd.emit   = EMIT_BAD_LENGTH;
            state_next = ST_HUNT;
          end else if (status.len_zero) begin
            state_next = ST_CRC_L;
          end else begin
            state_next = ST_PAYLOAD;
          end
        end
      end
      ST_PAYLOAD: begin
        if (take) begin
          cmd.capture = CAP_PAYLOAD;
          if (status.payload_done) begin
            state_next = ST_CRC_L;
          end
        end
      end
      ST_CRC_L: begin
        if (take) begin
          cmd.capture = CAP_CRC_L;
          state_next  = ST_CRC_H;
        end
      end
      ST_CRC_H: begin
        if (take) begin
          if (!status.crc_good) begin
            cmd.emit   = EMIT_BAD_CRC;
            state_next = ST_HUNT;
          end else if (status.hdr_len_zero) begin
            cmd.emit   = EMIT_EMPTY;
            state_next = ST_HUNT;
          end else begin
            cmd.replay_start = 1'b1;
            state_next       = ST_PRIME;
          end
        end
      end
      ST_PRIME: begin
        state_next = ST_REPLAY;
      end
      ST_REPLAY: begin
        if (status.out_free) begin
          cmd.emit        = EMIT_DATA;
          cmd.replay_step = 1'b1;
          if (status.replay_last) begin
            state_next = ST_HUNT;
          end
        end
      end
      default: begin
        state_next = ST_HUNT;
      end
    endcase
  end

endmodule

[hdl/crc16fp_dp.sv]
`timescale 1ns / 1ps
// frame parser datapath: config registers, header fields, crc, payload
// buffer and the result register; depends on crc16fp_pkg and crc16fp_ifs

module crc16fp_dp
  import crc16fp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] rx_byte,
  input  cmd_t       cmd,
  output status_t    status,
  crc16fp_cfg_if.sink  cfg,
  crc16fp_res_if.source res
);

  // configuration
  logic [7:0] start_byte;
  logic [7:0] expected_version;
  logic [5:0] length_limit;

  // frame fields
  logic [7:0]       frame_version;
  logic [7:0]       frame_type;
  logic [15:0]      frame_seq;
  logic [15:0]      hdr_len;
  logic [CNT_W-1:0] payload_count;
  logic [15:0]      running_crc;
  logic [7:0]       received_crc_low;

  // payload buffer with registered read
  logic [7:0]       payload_store [MAX_PAYLOAD];
  logic [7:0]       rd_data;
  logic [CNT_W-1:0] rd_ptr;
  logic [CNT_W-1:0] rd_addr;

  // result register
  logic        out_valid;
  kind_t       out_kind;
  logic [7:0]  out_type;
  logic [15:0] out_seq;
  logic [15:0] out_len;
  logic [7:0]  out_detail;
  logic [7:0]  out_data;
  logic        out_data_valid;
  logic        out_last;

  logic [15:0] len_full;
  logic [15:0] limit;
  logic [15:0] crc_in;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte       <= START_BYTE_RST;
      expected_version <= EXP_VER_RST;
      length_limit     <= LEN_LIMIT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_START_BYTE: start_byte       <= cfg.data;
        REG_EXP_VER:    expected_version <= cfg.data;
        REG_LEN_LIMIT:  length_limit     <= cfg.data[5:0];
        default: ;
      endcase
    end
  end

  assign len_full = {rx_byte, hdr_len[7:0]};
  assign limit = (16'(length_limit) > 16'(MAX_PAYLOAD)) ? 16'(MAX_PAYLOAD)
                                                         : 16'(length_limit);
  assign crc_in = (cmd.capture == CAP_VERSION) ? CRC_INIT : running_crc;

  always_comb begin
    status.start_match    = (rx_byte == start_byte);
    status.version_bad    = (frame_version != expected_version);
    status.len_bad        = (len_full > limit);
    status.len_zero       = (len_full == 16'd0);
    status.payload_done   = ((16'(payload_count) + 16'd1) >= hdr_len);
    status.crc_good       = ({rx_byte, received_crc_low} == running_crc);
    status.hdr_len_zero   = (hdr_len == 16'd0);
    status.replay_last    = ((16'(rd_ptr) + 16'd1) == hdr_len);
    status.out_free       = !out_valid || res.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_version    <= '0;
      frame_type       <= '0;
      frame_seq        <= '0;
      hdr_len          <= '0;
      payload_count    <= '0;
      running_crc      <= CRC_INIT;
      received_crc_low <= '0;
    end else begin
      case (cmd.capture)
        CAP_START: begin
          payload_count <= '0;
          running_crc   <= CRC_INIT;
        end
        CAP_VERSION: frame_version <= rx_byte;
        CAP_TYPE:    frame_type    <= rx_byte;
        CAP_SEQ_L:   frame_seq     <= {8'h00, rx_byte};
        CAP_SEQ_H:   frame_seq     <= {rx_byte, frame_seq[7:0]};
        CAP_LEN_L:   hdr_len       <= {8'h00, rx_byte};
        CAP_LEN_H:   hdr_len       <= len_full;
        CAP_PAYLOAD: payload_count <= payload_count + CNT_W'(1);
        CAP_CRC_L:   received_crc_low <= rx_byte;
        default: ;
      endcase
      case (cmd.capture) inside
        CAP_VERSION, CAP_TYPE, CAP_SEQ_L, CAP_SEQ_H, CAP_LEN_L, CAP_LEN_H,
        CAP_PAYLOAD: running_crc <= crc_step(crc_in, rx_byte);
        default: ;
      endcase
    end
  end

  // write during payload, read while replaying; never both
  assign rd_addr = cmd.replay_step ? rd_ptr + CNT_W'(1) : rd_ptr;

  always_ff @(posedge clk) begin
    if (cmd.capture == CAP_PAYLOAD) begin
      payload_store[payload_count[PTR_W-1:0]] <= rx_byte;
    end
    rd_data <= payload_store[rd_addr[PTR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
    end else if (cmd.replay_start) begin
      rd_ptr <= '0;
    end else if (cmd.replay_step) begin
      rd_ptr <= rd_ptr + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit != EMIT_NONE) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != EMIT_NONE) begin
      out_type       <= frame_type;
      out_seq        <= frame_seq;
      out_len        <= (cmd.capture == CAP_LEN_H) ? len_full : hdr_len;
      out_kind       <= KIND_GOOD;
      out_detail     <= 8'h00;
      out_data       <= 8'h00;
      out_data_valid <= 1'b0;
      out_last       <= 1'b1;
      case (cmd.emit)
        EMIT_DATA: begin
          out_data       <= rd_data;
          out_data_valid <= 1'b1;
          out_last       <= status.replay_last;
        end
        EMIT_BAD_VERSION: begin
          out_kind   <= KIND_BAD_VERSION;
          out_detail <= frame_version;
        end
        EMIT_BAD_LENGTH: begin
          out_kind   <= KIND_BAD_LENGTH;
          out_detail <= hdr_len[7:0];
        end
        EMIT_BAD_CRC: out_kind <= KIND_BAD_CRC;
        default: ;
      endcase
    end
  end

  assign res.valid        = out_valid;
  assign res.kind         = out_kind;
  assign res.pkt_type     = out_type;
  assign res.seq_number   = out_seq;
  assign res.pkt_len      = out_len;
  assign res.error_detail = out_detail;
  assign res.data_byte    = out_data;
  assign res.data_valid   = out_data_valid;
  assign res.last         = out_last;

endmodule

[hdl/crc16_frame_parser.sv]
`timescale 1ns / 1ps
// top level of the start-byte framed packet parser with crc-16/ccitt-false
// depends on crc16fp_pkg, crc16fp_ifs, crc16fp_ctrl, crc16fp_dp
//
//  channel  role    carries
//  -------  ------  ----------------------------------------------------------
//  rx       sink    one received byte per transaction
//  res      source  one result per transaction (verdict, header, payload byte)
//  cfg      sink    register write: 0 start byte, 1 version, 2 length limit
//
// one byte per cycle while parsing; the high length byte and the high crc
// byte wait only while the result register is still occupied
// a good frame replays its payload from the buffer: a prime state, then one
// result per cycle as res takes them
// rx is held off during replay; synchronous active-high rst returns to hunt
// the cfg channel is always ready; writes take effect on the next cycle

module crc16_frame_parser
  import crc16fp_pkg::*;
(
  input logic           clk,
  input logic           rst,
  crc16fp_rx_if.sink    rx,
  crc16fp_res_if.source res,
  crc16fp_cfg_if.sink   cfg
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  // phase sequencing and result scheduling
  crc16fp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  assign rx.ready = in_ready;

  // fields, crc, payload buffer and result register
  crc16fp_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .rx_byte (rx.rx_byte),
    .cmd     (cmd),
    .status  (status),
    .cfg     (cfg),
    .res     (res)
  );

endmodule
